@@ rtl/c2s_pkg.sv @@
`default_nettype none

package c2s_pkg;

    // Default build values
    localparam int COORD_WIDTH_DEF    = 16;
    localparam int ROTATION_STEPS_DEF = 16;

    // Result field widths
    localparam int RADIUS_W = 16;
    localparam int ANGLE_W  = 16;
    localparam longint RADIUS_MAX = 65535;

    // Angle accumulator in quarter binary units (four per output unit)
    localparam int ACC_W = 20;
    typedef logic signed [ACC_W-1:0] t_acc;
    localparam t_acc HALF_TURN_Q = t_acc'(131072);
    localparam t_acc ROUND_Q     = t_acc'(2);

    // atan(2^-i) in quarter binary units, rounded
    localparam int ATAN_ENTRIES = 32;
    localparam logic [16:0] ATAN_Q [0:ATAN_ENTRIES-1] = '{
        17'd32768, 17'd19344, 17'd10221, 17'd5188, 17'd2604, 17'd1303, 17'd652, 17'd326,
        17'd163,   17'd81,    17'd41,    17'd20,   17'd10,   17'd5,    17'd3,   17'd1,
        17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,   17'd0,
        17'd0,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,   17'd0
    };

endpackage

`default_nettype wire

@@ rtl/cartesian_to_spherical.sv @@
// Channel   Direction  Handshake         Payload
// input     in         i_valid/o_stall   i_x_coord, i_y_coord, i_z_coord
// output    out        o_valid/i_stall   o_radius, o_polar_angle, o_azimuth, o_zero_vector
//
// One item enters per cycle while o_stall is low. The pipeline is a bit-per-stage square root
// of the horizontal radius (RHO_W stages, 31 at default width) followed by one
// CORDIC micro-rotation per stage.
// Reset (i_rst_n low at a clock edge) empties the pipeline; payload is not cleared.
// The whole pipeline advances together; it holds only while a result sits on the
// output and i_stall is high, and o_stall follows that condition.

`default_nettype none

module cartesian_to_spherical #(
    parameter int COORD_WIDTH    = c2s_pkg::COORD_WIDTH_DEF,
    parameter int ROTATION_STEPS = c2s_pkg::ROTATION_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [COORD_WIDTH-1:0]   i_x_coord,
    input  logic signed [COORD_WIDTH-1:0]   i_y_coord,
    input  logic signed [COORD_WIDTH-1:0]   i_z_coord,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [c2s_pkg::RADIUS_W-1:0]    o_radius,
    output logic [c2s_pkg::ANGLE_W-1:0]     o_polar_angle,
    output logic [c2s_pkg::ANGLE_W-1:0]     o_azimuth,
    output logic                            o_zero_vector
);
    import c2s_pkg::*;

    localparam int CW        = COORD_WIDTH;
    localparam int RS        = ROTATION_STEPS;
    localparam int G         = (CW < 30) ? 30 - CW : 0;
    localparam int SUM_RAW   = 2 * CW + 2;
    localparam int SUM_W     = (SUM_RAW > 64) ? 64 : SUM_RAW;
    localparam int R_W       = SUM_W / 2;
    localparam int RHO_RAW   = 2 * CW + 2 + 2 * G;
    localparam int RHO_IN_W  = (RHO_RAW > 64) ? 64 : RHO_RAW;
    localparam int RHO_W     = RHO_IN_W / 2;
    localparam int A_W       = CW + G + 3;
    localparam int NSQ       = RHO_W;

    // Global advance: everything moves unless the output is held
    logic en;
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // Input register
    logic                   r_v1;
    logic signed [CW-1:0]   r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
        if (en) begin
            r_x <= i_x_coord;
            r_y <= i_y_coord;
            r_z <= i_z_coord;
        end
    end

    // Squares
    logic                   r_v2;
    logic [2*CW-1:0]        r_xx, r_yy, r_zz;
    logic signed [CW-1:0]   r_x2, r_y2, r_z2;
    logic                   r_zero2, r_xy02;
    logic signed [2*CW-1:0] pxx, pyy, pzz;

    assign pxx = r_x * r_x;
    assign pyy = r_y * r_y;
    assign pzz = r_z * r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_xx    <= pxx;
            r_yy    <= pyy;
            r_zz    <= pzz;
            r_x2    <= r_x;
            r_y2    <= r_y;
            r_z2    <= r_z;
            r_xy02  <= (r_x == '0) && (r_y == '0);
            r_zero2 <= (r_x == '0) && (r_y == '0) && (r_z == '0);
        end
    end

    // Square root pipelines: radius in the first R_W stages, horizontal radius in all
    logic                   r_sv    [0:NSQ];
    logic                   r_szero [0:NSQ];
    logic                   r_sxy0  [0:NSQ];
    logic signed [A_W-1:0]  r_sxa   [0:NSQ];
    logic signed [A_W-1:0]  r_sya   [0:NSQ];
    logic signed [A_W-1:0]  r_sza   [0:NSQ];
    logic [R_W+1:0]         r_rrem  [0:NSQ];
    logic [R_W-1:0]         r_rroot [0:NSQ];
    logic [SUM_W-1:0]       r_rrad  [0:NSQ];
    logic [RHO_W+1:0]       r_hrem  [0:NSQ];
    logic [RHO_W-1:0]       r_hroot [0:NSQ];
    logic [RHO_IN_W-1:0]    r_hrad  [0:NSQ];

    logic [2*CW:0]          sxy;
    logic [2*CW+1:0]        ssum;
    logic [RHO_RAW-1:0]     rho_rad;

    assign sxy     = {1'b0, r_xx} + {1'b0, r_yy};
    assign ssum    = {1'b0, sxy} + {2'b00, r_zz};
    assign rho_rad = RHO_RAW'(sxy) << (2 * G);

    // Sums and scaled coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r_v2;
        end
        if (en) begin
            r_szero[0] <= r_zero2;
            r_sxy0[0]  <= r_xy02;
            r_sxa[0]   <= A_W'(r_x2) <<< G;
            r_sya[0]   <= A_W'(r_y2) <<< G;
            r_sza[0]   <= A_W'(r_z2) <<< G;
            r_rrem[0]  <= '0;
            r_rroot[0] <= '0;
            r_rrad[0]  <= SUM_W'(ssum);
            r_hrem[0]  <= '0;
            r_hroot[0] <= '0;
            r_hrad[0]  <= RHO_IN_W'(rho_rad);
        end
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        logic [RHO_W+1:0] h_t, h_trial;
        logic             h_ge;

        assign h_t     = {r_hrem[k][RHO_W-1:0], r_hrad[k][RHO_IN_W-1 -: 2]};
        assign h_trial = {r_hroot[k], 2'b01};
        assign h_ge    = h_t >= h_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (en) begin
                r_sv[k+1] <= r_sv[k];
            end
            if (en) begin
                r_szero[k+1] <= r_szero[k];
                r_sxy0[k+1]  <= r_sxy0[k];
                r_sxa[k+1]   <= r_sxa[k];
                r_sya[k+1]   <= r_sya[k];
                r_sza[k+1]   <= r_sza[k];
                r_hrem[k+1]  <= h_ge ? h_t - h_trial : h_t;
                r_hroot[k+1] <= {r_hroot[k][RHO_W-2:0], h_ge};
                r_hrad[k+1]  <= r_hrad[k] << 2;
            end
        end

        if (k < R_W) begin : g_rad
            logic [R_W+1:0] r_t, r_trial;
            logic           r_ge;

            assign r_t     = {r_rrem[k][R_W-1:0], r_rrad[k][SUM_W-1 -: 2]};
            assign r_trial = {r_rroot[k], 2'b01};
            assign r_ge    = r_t >= r_trial;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rrem[k+1]  <= r_ge ? r_t - r_trial : r_t;
                    r_rroot[k+1] <= {r_rroot[k][R_W-2:0], r_ge};
                    r_rrad[k+1]  <= r_rrad[k] << 2;
                end
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rrem[k+1]  <= r_rrem[k];
                    r_rroot[k+1] <= r_rroot[k];
                    r_rrad[k+1]  <= r_rrad[k];
                end
            end
        end
    end

    // CORDIC entry: round the radius, fold the left half-plane
    logic                   r_cv    [0:RS];
    logic                   r_czero [0:RS];
    logic                   r_cxy0  [0:RS];
    logic [RADIUS_W-1:0]    r_crad  [0:RS];
    logic signed [A_W-1:0]  r_pa    [0:RS];
    logic signed [A_W-1:0]  r_pb    [0:RS];
    t_acc                   r_pacc  [0:RS];
    logic signed [A_W-1:0]  r_aa    [0:RS];
    logic signed [A_W-1:0]  r_ab    [0:RS];
    t_acc                   r_aacc  [0:RS];

    logic [R_W:0]           rad_up;
    logic [RADIUS_W-1:0]    rad_sat;
    logic signed [A_W-1:0]  rho_a;

    always_comb begin
        rad_up = {1'b0, r_rroot[NSQ]}
               + (R_W+1)'(r_rrem[NSQ] > {2'b00, r_rroot[NSQ]});
        if (64'(rad_up) > 64'(RADIUS_MAX)) begin
            rad_sat = RADIUS_W'(RADIUS_MAX);
        end else begin
            rad_sat = RADIUS_W'(rad_up);
        end
        rho_a = A_W'({1'b0, r_hroot[NSQ]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_sv[NSQ];
        end
        if (en) begin
            r_czero[0] <= r_szero[NSQ];
            r_cxy0[0]  <= r_sxy0[NSQ];
            r_crad[0]  <= rad_sat;
            if (r_sza[NSQ][A_W-1]) begin
                r_pa[0]   <= -r_sza[NSQ];
                r_pb[0]   <= -rho_a;
                r_pacc[0] <= HALF_TURN_Q;
            end else begin
                r_pa[0]   <= r_sza[NSQ];
                r_pb[0]   <= rho_a;
                r_pacc[0] <= '0;
            end
            if (r_sxa[NSQ][A_W-1]) begin
                r_aa[0]   <= -r_sxa[NSQ];
                r_ab[0]   <= -r_sya[NSQ];
                r_aacc[0] <= HALF_TURN_Q;
            end else begin
                r_aa[0]   <= r_sxa[NSQ];
                r_ab[0]   <= r_sya[NSQ];
                r_aacc[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage for both angles; hold once b reaches zero
    for (genvar i = 0; i < RS; i++) begin : g_cordic
        localparam t_acc STEP = t_acc'(ATAN_Q[i % ATAN_ENTRIES]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (en) begin
                r_cv[i+1] <= r_cv[i];
            end
            if (en) begin
                r_czero[i+1] <= r_czero[i];
                r_cxy0[i+1]  <= r_cxy0[i];
                r_crad[i+1]  <= r_crad[i];

                if (r_pb[i] == '0) begin
                    r_pa[i+1]   <= r_pa[i];
                    r_pb[i+1]   <= r_pb[i];
                    r_pacc[i+1] <= r_pacc[i];
                end else if (!r_pb[i][A_W-1]) begin
                    r_pa[i+1]   <= r_pa[i] + (r_pb[i] >>> i);
                    r_pb[i+1]   <= r_pb[i] - (r_pa[i] >>> i);
                    r_pacc[i+1] <= r_pacc[i] + STEP;
                end else begin
                    r_pa[i+1]   <= r_pa[i] - (r_pb[i] >>> i);
                    r_pb[i+1]   <= r_pb[i] + (r_pa[i] >>> i);
                    r_pacc[i+1] <= r_pacc[i] - STEP;
                end

                if (r_ab[i] == '0) begin
                    r_aa[i+1]   <= r_aa[i];
                    r_ab[i+1]   <= r_ab[i];
                    r_aacc[i+1] <= r_aacc[i];
                end else if (!r_ab[i][A_W-1]) begin
                    r_aa[i+1]   <= r_aa[i] + (r_ab[i] >>> i);
                    r_ab[i+1]   <= r_ab[i] - (r_aa[i] >>> i);
                    r_aacc[i+1] <= r_aacc[i] + STEP;
                end else begin
                    r_aa[i+1]   <= r_aa[i] - (r_ab[i] >>> i);
                    r_ab[i+1]   <= r_ab[i] + (r_aa[i] >>> i);
                    r_aacc[i+1] <= r_aacc[i] - STEP;
                end
            end
        end
    end

    // Clamp, round and wrap the angles; force zeros for the special cases
    logic                   r_out_v;
    logic [RADIUS_W-1:0]    r_radius;
    logic [ANGLE_W-1:0]     r_polar;
    logic [ANGLE_W-1:0]     r_azim;
    logic                   r_zero;
    t_acc                   p_clamp, p_rnd, a_rnd;

    always_comb begin
        if (r_pacc[RS][ACC_W-1]) begin
            p_clamp = '0;
        end else if (r_pacc[RS] > HALF_TURN_Q) begin
            p_clamp = HALF_TURN_Q;
        end else begin
            p_clamp = r_pacc[RS];
        end
        p_rnd = p_clamp + ROUND_Q;
        a_rnd = r_aacc[RS] + ROUND_Q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_cv[RS];
        end
        if (en) begin
            r_zero <= r_czero[RS];
            if (r_czero[RS]) begin
                r_radius <= '0;
                r_polar  <= '0;
                r_azim   <= '0;
            end else begin
                r_radius <= r_crad[RS];
                r_polar  <= p_rnd[ANGLE_W+1:2];
                r_azim   <= r_cxy0[RS] ? '0 : a_rnd[ANGLE_W+1:2];
            end
        end
    end

    assign o_valid       = r_out_v;
    assign o_radius      = r_radius;
    assign o_polar_angle = r_polar;
    assign o_azimuth     = r_azim;
    assign o_zero_vector = r_zero;

endmodule

`default_nettype wire

@@ rtl/c2s_checker.sv @@
`default_nettype none

module c2s_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_stall,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic [c2s_pkg::RADIUS_W-1:0]    o_radius,
    input  logic [c2s_pkg::ANGLE_W-1:0]     o_polar_angle,
    input  logic [c2s_pkg::ANGLE_W-1:0]     o_azimuth,
    input  logic                            o_zero_vector
);
    import c2s_pkg::*;

    localparam logic [ANGLE_W-1:0] POLAR_MAX = ANGLE_W'(32768);

    // Upstream is held back only while a result waits on the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A zero vector reports all zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |->
            (o_radius == '0 && o_polar_angle == '0 && o_azimuth == '0))
        else $error("zero vector with nonzero fields");

    // Any other point has a nonzero radius and a polar angle within a half turn
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_zero_vector) |->
            (o_radius != '0 && o_polar_angle <= POLAR_MAX))
        else $error("bad radius or polar angle");

    // A held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_radius) && $stable(o_polar_angle)
             && $stable(o_azimuth) && $stable(o_zero_vector)))
        else $error("held result changed");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_radius      (o_radius),
    .o_polar_angle (o_polar_angle),
    .o_azimuth     (o_azimuth),
    .o_zero_vector (o_zero_vector)
);

`default_nettype wire

@@ test/cartesian_to_spherical_tb.sv @@
`default_nettype none

module cartesian_to_spherical_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c2s_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int STEPS     = ROTATION_STEPS_DEF;
    localparam int GUARD     = (CW < 30) ? 30 - CW : 0;
    localparam int LATENCY   = 2 * CW - 1 + STEPS + 5;
    localparam int IDLE_LIMIT = 20000;
    localparam longint HALF_Q = 131072;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [ANGLE_W-1:0]  polar;
        logic [ANGLE_W-1:0]  azimuth;
        logic                zero;
    } t_sph;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [CW-1:0] i_x_coord = '0;
    logic signed [CW-1:0] i_y_coord = '0;
    logic signed [CW-1:0] i_z_coord = '0;
    logic o_stall, o_valid, o_zero_vector;
    logic [RADIUS_W-1:0] o_radius;
    logic [ANGLE_W-1:0]  o_polar_angle, o_azimuth;

    t_sph   sph_expected[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     stall_left = 0;
    bit     in_reset = 1'b1;

    cartesian_to_spherical dut (.*);

    always #10 i_clk = ~i_clk;

    // Integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    // Vectoring rotation: atan2(b, a) in quarter units
    function automatic longint vector_angle(longint a, longint b);
        longint acc, na, nb;
        acc = 0;
        if (a < 0) begin
            a = -a;
            b = -b;
            acc = HALF_Q;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            if (b == 0) break;
            if (b > 0) begin
                na = a + (b >>> i);
                nb = b - (a >>> i);
                acc += longint'(ATAN_Q[i]);
            end else begin
                na = a - (b >>> i);
                nb = b + (a >>> i);
                acc -= longint'(ATAN_Q[i]);
            end
            a = na;
            b = nb;
        end
        return acc;
    endfunction

    function automatic t_sph to_spherical(logic signed [CW-1:0] xc,
                                          logic signed [CW-1:0] yc,
                                          logic signed [CW-1:0] zc);
        t_sph res;
        longint x, y, z, pacc, aacc;
        longint unsigned sxy, s, r, rho;
        x = xc;
        y = yc;
        z = zc;
        res = '0;
        if (x == 0 && y == 0 && z == 0) begin
            res.zero = 1'b1;
            return res;
        end
        sxy = x * x + y * y;
        s = sxy + z * z;
        r = root_floor(s);
        if (s - r * r > r) r++;
        if (r > RADIUS_MAX) r = RADIUS_MAX;
        rho = root_floor(sxy << (2 * GUARD));
        pacc = vector_angle(z <<< GUARD, longint'(rho));
        if (pacc < 0) pacc = 0;
        if (pacc > HALF_Q) pacc = HALF_Q;
        res.radius = r[RADIUS_W-1:0];
        res.polar = ANGLE_W'((pacc + 2) >>> 2);
        if (!(x == 0 && y == 0)) begin
            aacc = vector_angle(x <<< GUARD, y <<< GUARD);
            res.azimuth = ANGLE_W'((aacc + 2) >>> 2);
        end
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int gap_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one item and wait for acceptance; valid stays high for a following item
    task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] z, bit with_gaps);
        int gap;
        gap = with_gaps ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        i_z_coord <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sph_expected.push_back(to_spherical(x, y, z));
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sph_expected.size() != 0) @(posedge i_clk);
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_sph want;
        if (!in_reset) begin
            if (o_valid && !i_stall) begin
                idle_cycles <= 0;
                if (sph_expected.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    mismatches++;
                end else begin
                    want = sph_expected.pop_front();
                    if (o_radius != want.radius) report("radius", o_radius, want.radius);
                    if (o_polar_angle != want.polar)
                        report("polar", o_polar_angle, want.polar);
                    if (o_azimuth != want.azimuth)
                        report("azimuth", o_azimuth, want.azimuth);
                    if (o_zero_vector != want.zero)
                        report("zero", o_zero_vector, want.zero);
                end
            end else if (i_valid && !o_stall) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stall the output side at random, now and then for a long stretch, with quiet stretches
    always @(posedge i_clk) begin
        int phase;
        phase = int'($realtime / 20.0);
        if (in_reset || (phase / 2000) % 3 == 0) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 99) < 2) begin
            stall_left <= $urandom_range(10, 60);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return CW'($urandom_range(0, 1) ? -32768 : 32767);
            1: return CW'($signed($urandom_range(0, 6)) - 3);
            2: return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [CW-1:0] v[6];
        v = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh8001};
        send_point(0, 0, 0, 0);
        send_point(0, 0, 100, 0);
        send_point(0, 0, -100, 0);
        send_point(-32768, -32768, -32768, 0);
        send_point(32767, 32767, 32767, 0);
        send_point(-1, 0, 0, 0);
        send_point(-5, -1, 0, 0);
        send_point(0, -7, 0, 0);
        send_point(-32768, 0, 0, 0);
        send_point(3, 0, 32767, 0);
        send_point(1, -1, -32768, 0);
        for (int i = 0; i < 12; i++)
            send_point(v[$urandom_range(0, 5)], v[$urandom_range(0, 5)],
                       v[$urandom_range(0, 5)], 0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i % 200 < 150);
    endtask

    task automatic test_pause_drain();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_reset = 1'b0;
        test_extremes();
        test_pause_drain();
        test_random(1580);
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && sph_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
